// ===== hw/rtl/brd_pkg.sv =====
package brd_pkg;

  localparam int MAX_BOXES_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int HALF_W          = 31;
  localparam int EVENT_CAP       = 16;
  localparam int EVCNT_W         = $clog2(EVENT_CAP + 1);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_VIS    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    EV_ENTER = 2'd0,
    EV_EXIT  = 2'd1,
    EV_DONE  = 2'd2
  } event_kind_t;

  // Per-cell control from the sweep controller.
  typedef struct packed {
    logic load;
    logic vis_we;
    logic vis_val;
    logic shift;
    logic clear;
  } brd_cell_ctl_t;

  // Event proposed by the cell that holds the sweep token.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } brd_cell_ev_t;

endpackage

// ===== hw/rtl/brd_in_if.sv =====
interface brd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  box_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] size_x;
  logic [31:0] size_y;
  logic [31:0] size_z;
  logic        fire_once;
  logic        enter_enabled;
  logic        exit_enabled;
  logic        visible_value;

  modport source (
    output valid, action, box_index, pos_x, pos_y, pos_z, size_x, size_y, size_z,
           fire_once, enter_enabled, exit_enabled, visible_value,
    input  ready
  );
  modport sink (
    input  valid, action, box_index, pos_x, pos_y, pos_z, size_x, size_y, size_z,
           fire_once, enter_enabled, exit_enabled, visible_value,
    output ready
  );
endinterface

// ===== hw/rtl/brd_evt_if.sv =====
interface brd_evt_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_box;
  logic [1:0] event_kind;
  logic       last;

  modport source (output valid, event_box, event_kind, last, input ready);
  modport sink (input valid, event_box, event_kind, last, output ready);
endinterface

// ===== hw/rtl/brd_cell.sv =====
module brd_cell
  import brd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brd_cell_ctl_t                 ctl,
  input  logic signed [COORD_WIDTH-1:0] ld_cx,
  input  logic signed [COORD_WIDTH-1:0] ld_cy,
  input  logic signed [COORD_WIDTH-1:0] ld_cz,
  input  logic [HALF_W-1:0]             ld_hx,
  input  logic [HALF_W-1:0]             ld_hy,
  input  logic [HALF_W-1:0]             ld_hz,
  input  logic                          ld_once,
  input  logic                          ld_enter,
  input  logic                          ld_exit,
  input  logic                          tok_in,
  input  logic signed [COORD_WIDTH-1:0] px_in,
  input  logic signed [COORD_WIDTH-1:0] py_in,
  input  logic signed [COORD_WIDTH-1:0] pz_in,
  output logic                          tok,
  output logic signed [COORD_WIDTH-1:0] px,
  output logic signed [COORD_WIDTH-1:0] py,
  output logic signed [COORD_WIDTH-1:0] pz,
  output brd_cell_ev_t                  ev
);

  localparam int CMP_W = ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W) + 1;

  logic signed [COORD_WIDTH-1:0] cx, cy, cz;
  logic [HALF_W-1:0]             hx, hy, hz;
  logic visible, in_box, triggered, once, enter_en, exit_en;
  logic now_in, act;
  logic in_box_next, triggered_next;

  function automatic logic axis_in(input logic signed [COORD_WIDTH-1:0] p,
                                   input logic signed [COORD_WIDTH-1:0] c,
                                   input logic [HALF_W-1:0] h);
    logic signed [CMP_W-1:0] pe, ce, he, lo, hi;
    pe = CMP_W'(p);
    ce = CMP_W'(c);
    he = signed'(CMP_W'(h));
    lo = ce - he;
    hi = ce + he;
    return (pe >= lo) && (pe <= hi);
  endfunction

  always_comb begin
    now_in = axis_in(px, cx, hx) && axis_in(py, cy, hy) && axis_in(pz, cz, hz);
    act = tok && visible;
    in_box_next = in_box;
    triggered_next = triggered;
    ev = '0;
    if (now_in) begin
      if (!in_box && (!once || !triggered)) begin
        ev.valid = act && enter_en;
        ev.kind = EV_ENTER;
        if (once) begin
          triggered_next = 1'b1;
        end
      end
      in_box_next = 1'b1;
    end else begin
      ev.valid = act && in_box && exit_en;
      ev.kind = EV_EXIT;
      in_box_next = 1'b0;
      if (!once) begin
        triggered_next = 1'b0;
      end
    end
  end

  // Token and probe travel one cell per shift; the box table entry stays put.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.clear) begin
      tok <= 1'b0;
    end else if (ctl.shift) begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      px <= px_in;
      py <= py_in;
      pz <= pz_in;
    end
    if (ctl.load) begin
      cx <= ld_cx;
      cy <= ld_cy;
      cz <= ld_cz;
      hx <= ld_hx;
      hy <= ld_hy;
      hz <= ld_hz;
      visible <= 1'b1;
      in_box <= 1'b0;
      triggered <= 1'b0;
      once <= ld_once;
      enter_en <= ld_enter;
      exit_en <= ld_exit;
    end else if (ctl.vis_we) begin
      visible <= ctl.vis_val;
    end else if (ctl.shift && act) begin
      in_box <= in_box_next;
      triggered <= triggered_next;
    end
  end

endmodule

// ===== hw/rtl/box_region_enter_exit_detector_unit.sv =====
// Channel   Dir  Beat contents
// items     in   action, box_index, pos_x/y/z, size_x/y/z, fire_once, enter/exit_enabled,
//                visible_value
// events    out  event_box, event_kind, last
//
// Load and visibility beats are written into the cell table when accepted. A position beat
// is accepted and starts the token at cell 0, the token walks the cell chain one stored box
// per step, and the done beat is posted at the end. A stall on events freezes the chain.
// Synchronous reset clears the box count, the sweep controller, the tokens and the output valid.
// The box table itself is not cleared; boxes past the count are never swept.
module box_region_enter_exit_detector_unit
  import brd_pkg::*;
#(
  parameter int MAX_BOXES   = MAX_BOXES_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  brd_in_if.sink    items,
  brd_evt_if.source events
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  typedef enum logic {S_IDLE, S_SWEEP} state_t;

  state_t                state;
  logic [CNT_W-1:0]      box_count;
  logic [CNT_W-1:0]      pos;
  logic [EVCNT_W-1:0]    ev_cnt;
  logic                  evt_valid;
  logic [3:0]            evt_box;
  logic [1:0]            evt_kind;
  logic                  evt_last;

  logic                  accept, adv, at_end, shift, clear;
  logic [CNT_W+3:0]      pos_ext;
  logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
  logic [FIELD_W+COORD_WIDTH-1:0] ext_x, ext_y, ext_z;
  brd_cell_ev_t          sel_ev;

  brd_cell_ctl_t                 ctl [MAX_BOXES];
  brd_cell_ev_t                  ev  [MAX_BOXES];
  logic                          tok [MAX_BOXES];
  logic signed [COORD_WIDTH-1:0] cpx [MAX_BOXES];
  logic signed [COORD_WIDTH-1:0] cpy [MAX_BOXES];
  logic signed [COORD_WIDTH-1:0] cpz [MAX_BOXES];
  logic [MAX_BOXES-1:0]          tok_vec;

  assign items.ready = (state == S_IDLE);
  assign accept = items.valid && items.ready;
  assign adv = !evt_valid || events.ready;
  assign at_end = (pos == box_count);
  assign shift = (accept && items.action == ACT_SAMPLE) ||
                 (state == S_SWEEP && adv && !at_end);
  assign clear = (state == S_SWEEP) && adv && at_end;
  assign pos_ext = {4'd0, pos};

  // Coordinates are the low COORD_WIDTH bits of the field, zero-filled above it.
  assign ext_x = {{COORD_WIDTH{1'b0}}, items.pos_x};
  assign ext_y = {{COORD_WIDTH{1'b0}}, items.pos_y};
  assign ext_z = {{COORD_WIDTH{1'b0}}, items.pos_z};
  assign in_x = signed'(ext_x[COORD_WIDTH-1:0]);
  assign in_y = signed'(ext_y[COORD_WIDTH-1:0]);
  assign in_z = signed'(ext_z[COORD_WIDTH-1:0]);

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    logic                          tin;
    logic signed [COORD_WIDTH-1:0] xin, yin, zin;

    if (i == 0) begin : g_head
      assign tin = (state == S_IDLE);
      assign xin = in_x;
      assign yin = in_y;
      assign zin = in_z;
    end else begin : g_link
      assign tin = tok[i-1];
      assign xin = cpx[i-1];
      assign yin = cpy[i-1];
      assign zin = cpz[i-1];
    end

    always_comb begin
      ctl[i].load = accept && (items.action == ACT_LOAD) &&
                    (box_count == CNT_W'(i));
      ctl[i].vis_we = accept && (items.action == ACT_VIS) &&
                      (32'(items.box_index) == 32'(i)) && (CNT_W'(i) < box_count);
      ctl[i].vis_val = items.visible_value;
      ctl[i].shift = shift;
      ctl[i].clear = clear;
    end

    assign tok_vec[i] = tok[i];

    brd_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .ld_cx    (in_x),
      .ld_cy    (in_y),
      .ld_cz    (in_z),
      .ld_hx    (items.size_x[FIELD_W-1:1]),
      .ld_hy    (items.size_y[FIELD_W-1:1]),
      .ld_hz    (items.size_z[FIELD_W-1:1]),
      .ld_once  (items.fire_once),
      .ld_enter (items.enter_enabled),
      .ld_exit  (items.exit_enabled),
      .tok_in   (tin),
      .px_in    (xin),
      .py_in    (yin),
      .pz_in    (zin),
      .tok      (tok[i]),
      .px       (cpx[i]),
      .py       (cpy[i]),
      .pz       (cpz[i]),
      .ev       (ev[i])
    );
  end

  // At most one cell holds the token, so the proposals merge by OR.
  always_comb begin
    sel_ev = '0;
    for (int i = 0; i < MAX_BOXES; i++) begin
      sel_ev.valid = sel_ev.valid | ev[i].valid;
      sel_ev.kind  = sel_ev.kind | (ev[i].valid ? ev[i].kind : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      box_count <= '0;
      pos <= '0;
      ev_cnt <= '0;
      evt_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (evt_valid && events.ready) begin
            evt_valid <= 1'b0;
          end
          if (accept) begin
            if (items.action == ACT_LOAD && box_count != CNT_W'(MAX_BOXES)) begin
              box_count <= box_count + CNT_W'(1);
            end else if (items.action == ACT_SAMPLE) begin
              state <= S_SWEEP;
              pos <= '0;
              ev_cnt <= '0;
            end
          end
        end
        S_SWEEP: begin
          if (adv) begin
            if (at_end) begin
              evt_valid <= 1'b1;
              evt_box <= 4'd0;
              evt_kind <= EV_DONE;
              evt_last <= 1'b1;
              state <= S_IDLE;
            end else begin
              pos <= pos + CNT_W'(1);
              if (sel_ev.valid && ev_cnt < EVCNT_W'(EVENT_CAP)) begin
                evt_valid <= 1'b1;
                evt_box <= pos_ext[3:0];
                evt_kind <= sel_ev.kind;
                evt_last <= 1'b0;
                ev_cnt <= ev_cnt + EVCNT_W'(1);
              end else begin
                // The output register is empty or its beat is taken this cycle.
                evt_valid <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign events.valid = evt_valid;
  assign events.event_box = evt_box;
  assign events.event_kind = evt_kind;
  assign events.last = evt_last;

  a_tok_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("more than one cell holds the sweep token");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> pos <= box_count)
    else $error("sweep position ran past the box count");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_last |-> evt_kind == EV_DONE && evt_box == 4'd0)
    else $error("final beat of a sweep is not a done beat");

  a_no_token_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && $past(state) == S_IDLE |-> tok_vec == '0)
    else $error("token left in the chain after a sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CNT_W'(MAX_BOXES))
    else $error("box count exceeds capacity");

endmodule
